### rtl/bw3_pkg.sv
`timescale 1ns / 1ps

package bw3_pkg;

    // Coordinate, edge and dot-product widths.
    localparam int CW = 16;
    localparam int EW = CW + 1;
    localparam int SW = 2 * EW;
    localparam int DW = SW + 2;
    localparam int HW = DW / 2;
    localparam int PW = 2 * DW;

    // Divider widths: remainder, numerator magnitude, quotient.
    localparam int RW = 68;
    localparam int MW = 69;
    localparam int FW = 16;
    localparam int QW = MW + FW;
    localparam int AW = QW + 3;

    // Register stages ahead of the output register.
    localparam int NS = QW + 10;

    // Dot product slots.
    localparam int D00 = 0;
    localparam int D01 = 1;
    localparam int D11 = 2;
    localparam int D20 = 3;
    localparam int D21 = 4;

    // Wide product slots.
    localparam int P_D00_D11 = 0;
    localparam int P_D01_D01 = 1;
    localparam int P_D11_D20 = 2;
    localparam int P_D01_D21 = 3;
    localparam int P_D00_D21 = 4;
    localparam int P_D01_D20 = 5;

    typedef logic signed [EW-1:0]     diff_t;
    typedef logic signed [SW-1:0]     sq_t;
    typedef logic signed [DW-1:0]     dot_t;
    typedef logic signed [PW-1:0]     prod_t;
    typedef logic signed [2*HW+1:0]   mid_t;
    typedef logic signed [QW:0]       quot_t;
    typedef logic signed [AW-1:0]     sum_t;
    typedef logic signed [31:0]       weight_t;

    localparam sum_t    ONE_Q16    = sum_t'(65536);
    localparam weight_t WEIGHT_MAX = 32'sh7fff_ffff;
    localparam weight_t WEIGHT_MIN = 32'sh8000_0000;

    // Partial products of one split 36 x 36 multiplication.
    typedef struct packed {
        logic        [2*HW-1:0] ll;
        logic signed [2*HW:0]   lh;
        logic signed [2*HW:0]   hl;
        logic signed [2*HW-1:0] hh;
    } part_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] dvd;
    } div_lane_t;

    typedef struct packed {
        div_lane_t     b;
        div_lane_t     c;
        logic [RW-1:0] den;
        logic          sign_b;
        logic          sign_c;
        logic          degen;
    } div_stage_t;

    function automatic part_t split_mul(dot_t a, dot_t b);
        logic        [HW-1:0] al;
        logic        [HW-1:0] bl;
        logic signed [HW-1:0] ah;
        logic signed [HW-1:0] bh;
        part_t                p;
        al   = a[HW-1:0];
        bl   = b[HW-1:0];
        ah   = a[DW-1:HW];
        bh   = b[DW-1:HW];
        p.ll = al * bl;
        p.lh = $signed({1'b0, al}) * bh;
        p.hl = ah * $signed({1'b0, bl});
        p.hh = ah * bh;
        return p;
    endfunction

    // One restoring division step: one quotient bit enters the low end.
    function automatic div_lane_t div_step(div_lane_t x, logic [RW-1:0] den);
        logic [RW:0]   trial;
        logic [RW+1:0] diff;
        div_lane_t     y;
        trial = {x.rem, x.dvd[QW-1]};
        diff  = {1'b0, trial} - {2'b00, den};
        y.rem = diff[RW+1] ? trial[RW-1:0] : diff[RW-1:0];
        y.dvd = {x.dvd[QW-2:0], ~diff[RW+1]};
        return y;
    endfunction

    function automatic weight_t sat32(sum_t v);
        weight_t r;
        if ((&v[AW-1:31]) || !(|v[AW-1:31])) begin
            r = v[31:0];
        end
        else if (v[AW-1]) begin
            r = WEIGHT_MIN;
        end
        else begin
            r = WEIGHT_MAX;
        end
        return r;
    endfunction

endpackage

### rtl/barycentric_weights_3d.sv
// Barycentric weights of a point P against a triangle ABC in 3D. Coordinates are signed
// Q8.8; weights come out signed Q15.16, truncated toward zero and saturated to 32 bits,
// and weight A is one minus the unsaturated weights B and C. A point off the plane gets
// the weights of its projection. When the determinant is zero the weights are zero and
// degenerate is set. The datapath is a 96-register pipeline: edge vectors, squares,
// dot products, split wide multiplies, the determinant and numerators, then an 85-step
// restoring divider with one quotient bit per stage for each of the two weights, then
// sign fix, weight A and saturation. A word is taken every cycle unless the output stalls;
// a stalled output freezes the whole pipeline, so throughput is one word per cycle
// whenever the output side takes results as they come.
`timescale 1ns / 1ps

module barycentric_weights_3d
    import bw3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   point_x,
    input  logic signed [15:0]   point_y,
    input  logic signed [15:0]   point_z,
    input  logic signed [15:0]   corner_a_x,
    input  logic signed [15:0]   corner_a_y,
    input  logic signed [15:0]   corner_a_z,
    input  logic signed [15:0]   corner_b_x,
    input  logic signed [15:0]   corner_b_y,
    input  logic signed [15:0]   corner_b_z,
    input  logic signed [15:0]   corner_c_x,
    input  logic signed [15:0]   corner_c_y,
    input  logic signed [15:0]   corner_c_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   weight_a,
    output logic signed [31:0]   weight_b,
    output logic signed [31:0]   weight_c,
    output logic                 degenerate
);

    // The whole pipeline advances together whenever the output register can take a word.
    logic advance;

    logic [NS-1:0] v_reg;
    logic          out_valid_reg;

    diff_t      e0_reg [3];
    diff_t      e1_reg [3];
    diff_t      e2_reg [3];
    diff_t      e0_next [3];
    diff_t      e1_next [3];
    diff_t      e2_next [3];
    sq_t        sq_reg [15];
    sq_t        sq_next [15];
    dot_t       d_reg [5];
    dot_t       d_next [5];
    part_t      pp_reg [6];
    part_t      pp_next [6];
    prod_t      base_reg [6];
    prod_t      base_next [6];
    mid_t       mid_reg [6];
    mid_t       mid_next [6];
    prod_t      prod_reg [6];
    prod_t      prod_next [6];
    prod_t      den_reg;
    prod_t      nb_reg;
    prod_t      nc_reg;
    prod_t      den_next;
    prod_t      nb_next;
    prod_t      nc_next;
    div_stage_t div_reg [QW+1];
    div_stage_t div_next [QW+1];
    quot_t      qb_reg;
    quot_t      qc_reg;
    quot_t      qb_next;
    quot_t      qc_next;
    logic       degen_q_reg;
    sum_t       qa_reg;
    sum_t       qa_next;
    weight_t    wb_reg;
    weight_t    wc_reg;
    logic       degen_s_reg;
    weight_t    weight_a_reg;
    weight_t    weight_b_reg;
    weight_t    weight_c_reg;
    logic       degenerate_reg;
    prod_t      nb_mag;
    prod_t      nc_mag;
    quot_t      qb_mag;
    quot_t      qc_mag;

    assign advance   = out_ready || !out_valid_reg;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign weight_a  = weight_a_reg;
    assign weight_b  = weight_b_reg;
    assign weight_c  = weight_c_reg;
    assign degenerate = degenerate_reg;

    // Edges e0 = B - A, e1 = C - A and the offset e2 = P - A.
    always_comb
    begin
        e0_next[0] = diff_t'(corner_b_x) - diff_t'(corner_a_x);
        e0_next[1] = diff_t'(corner_b_y) - diff_t'(corner_a_y);
        e0_next[2] = diff_t'(corner_b_z) - diff_t'(corner_a_z);
        e1_next[0] = diff_t'(corner_c_x) - diff_t'(corner_a_x);
        e1_next[1] = diff_t'(corner_c_y) - diff_t'(corner_a_y);
        e1_next[2] = diff_t'(corner_c_z) - diff_t'(corner_a_z);
        e2_next[0] = diff_t'(point_x) - diff_t'(corner_a_x);
        e2_next[1] = diff_t'(point_y) - diff_t'(corner_a_y);
        e2_next[2] = diff_t'(point_z) - diff_t'(corner_a_z);
    end

    // Component products, grouped by dot product in slot order.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_next[3*D00 + k] = e0_reg[k] * e0_reg[k];
            sq_next[3*D01 + k] = e0_reg[k] * e1_reg[k];
            sq_next[3*D11 + k] = e1_reg[k] * e1_reg[k];
            sq_next[3*D20 + k] = e2_reg[k] * e0_reg[k];
            sq_next[3*D21 + k] = e2_reg[k] * e1_reg[k];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            d_next[j] = dot_t'(sq_reg[3*j]) + dot_t'(sq_reg[3*j + 1])
                      + dot_t'(sq_reg[3*j + 2]);
        end
    end

    // The determinant and both numerators need six 36 x 36 products. Each is
    // split into four partial products of about 18 x 18 and summed over two stages.
    always_comb
    begin
        pp_next[P_D00_D11] = split_mul(d_reg[D00], d_reg[D11]);
        pp_next[P_D01_D01] = split_mul(d_reg[D01], d_reg[D01]);
        pp_next[P_D11_D20] = split_mul(d_reg[D11], d_reg[D20]);
        pp_next[P_D01_D21] = split_mul(d_reg[D01], d_reg[D21]);
        pp_next[P_D00_D21] = split_mul(d_reg[D00], d_reg[D21]);
        pp_next[P_D01_D20] = split_mul(d_reg[D01], d_reg[D20]);
    end

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            // The low product is below the weight of the high one, so they simply abut.
            base_next[j] = $signed({pp_reg[j].hh, pp_reg[j].ll});
            mid_next[j]  = mid_t'(pp_reg[j].lh) + mid_t'(pp_reg[j].hl);
            prod_next[j] = base_reg[j] + (prod_t'(mid_reg[j]) <<< HW);
        end
    end

    always_comb
    begin
        den_next = prod_reg[P_D00_D11] - prod_reg[P_D01_D01];
        nb_next  = prod_reg[P_D11_D20] - prod_reg[P_D01_D21];
        nc_next  = prod_reg[P_D00_D21] - prod_reg[P_D01_D20];
    end

    // Divider entry. The determinant is never negative, so only the numerators carry
    // a sign; their magnitudes are scaled by 2^16 for the Q15.16 quotient.
    always_comb
    begin
        nb_mag = nb_reg[PW-1] ? -nb_reg : nb_reg;
        nc_mag = nc_reg[PW-1] ? -nc_reg : nc_reg;
        div_next[0].b.rem  = '0;
        div_next[0].b.dvd  = {nb_mag[MW-1:0], {FW{1'b0}}};
        div_next[0].c.rem  = '0;
        div_next[0].c.dvd  = {nc_mag[MW-1:0], {FW{1'b0}}};
        div_next[0].den    = den_reg[RW-1:0];
        div_next[0].sign_b = nb_reg[PW-1];
        div_next[0].sign_c = nc_reg[PW-1];
        div_next[0].degen  = (den_reg == '0);
        for (int k = 1; k <= QW; k++)
        begin
            div_next[k].b      = div_step(div_reg[k-1].b, div_reg[k-1].den);
            div_next[k].c      = div_step(div_reg[k-1].c, div_reg[k-1].den);
            div_next[k].den    = div_reg[k-1].den;
            div_next[k].sign_b = div_reg[k-1].sign_b;
            div_next[k].sign_c = div_reg[k-1].sign_c;
            div_next[k].degen  = div_reg[k-1].degen;
        end
    end

    // After the last step the dividend register holds the quotient magnitude.
    always_comb
    begin
        qb_mag  = quot_t'({1'b0, div_reg[QW].b.dvd});
        qc_mag  = quot_t'({1'b0, div_reg[QW].c.dvd});
        qb_next = div_reg[QW].sign_b ? -qb_mag : qb_mag;
        qc_next = div_reg[QW].sign_c ? -qc_mag : qc_mag;
        qa_next = ONE_Q16 - sum_t'(qb_reg) - sum_t'(qc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg         <= {v_reg[NS-2:0], in_valid};
            out_valid_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e0_reg[k] <= e0_next[k];
                e1_reg[k] <= e1_next[k];
                e2_reg[k] <= e2_next[k];
            end
            for (int k = 0; k < 15; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            for (int j = 0; j < 5; j++)
            begin
                d_reg[j] <= d_next[j];
            end
            for (int j = 0; j < 6; j++)
            begin
                pp_reg[j]   <= pp_next[j];
                base_reg[j] <= base_next[j];
                mid_reg[j]  <= mid_next[j];
                prod_reg[j] <= prod_next[j];
            end
            den_reg <= den_next;
            nb_reg  <= nb_next;
            nc_reg  <= nc_next;
            for (int k = 0; k <= QW; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            qb_reg         <= qb_next;
            qc_reg         <= qc_next;
            degen_q_reg    <= div_reg[QW].degen;
            qa_reg         <= qa_next;
            wb_reg         <= sat32(sum_t'(qb_reg));
            wc_reg         <= sat32(sum_t'(qc_reg));
            degen_s_reg    <= degen_q_reg;
            weight_a_reg   <= degen_s_reg ? '0 : sat32(qa_reg);
            weight_b_reg   <= degen_s_reg ? '0 : wb_reg;
            weight_c_reg   <= degen_s_reg ? '0 : wc_reg;
            degenerate_reg <= degen_s_reg;
        end
    end

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> weight_a == '0 && weight_b == '0 && weight_c == '0)
        else $error("degenerate word with nonzero weights");

    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate
        && weight_a != WEIGHT_MAX && weight_a != WEIGHT_MIN
        && weight_b != WEIGHT_MAX && weight_b != WEIGHT_MIN
        && weight_c != WEIGHT_MAX && weight_c != WEIGHT_MIN
        |-> (34'(weight_a) + 34'(weight_b) + 34'(weight_c)) == 34'sd65536)
        else $error("unsaturated weights do not sum to one");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(v_reg))
        else $error("pipeline moved while stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held off with empty output register");
`endif

endmodule
